>>> hdl/min_priority_queue_top_assert.svh
// Assertion macros shared by the min priority queue checker.
`ifndef MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mpq_pkg.sv
// Shared constants and control types for the min priority queue.
package mpq_pkg;

    localparam int KEY_W            = 32;
    localparam int HANDLE_W         = 16;
    localparam int CMD_W            = 2;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic                do_push;
        logic                do_pop;
        logic                do_clear;
        logic                load;
        logic [STATUS_W-1:0] status_code;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

>>> hdl/mpq_ctrl.sv
// Controller: handshake state machine and command decode for the queue.
module mpq_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [mpq_pkg::CMD_W-1:0] cmd,
    output logic                      result_valid,
    input  logic                      result_stall,
    input  mpq_pkg::dp_stat_t         stat,
    output mpq_pkg::ctl_t             ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // Handshake: the result register frees up when the word is taken
    assign result_valid = (state_reg == S_HOLD);
    assign item_stall   = (state_reg == S_HOLD) && result_stall;
    assign accept       = item_valid && !item_stall;

    // Command decode
    always_comb
    begin
        ctl.load        = accept;
        ctl.do_push     = 1'b0;
        ctl.do_pop      = 1'b0;
        ctl.do_clear    = 1'b0;
        ctl.status_code = mpq_pkg::ST_DONE;
        unique case (cmd)
            mpq_pkg::CMD_PUSH:
            begin
                ctl.do_push = accept && !stat.full;
                if (stat.full)
                begin
                    ctl.status_code = mpq_pkg::ST_FULL;
                end
            end
            mpq_pkg::CMD_POP:
            begin
                ctl.do_pop = accept && !stat.empty;
                if (stat.empty)
                begin
                    ctl.status_code = mpq_pkg::ST_EMPTY;
                end
            end
            mpq_pkg::CMD_CLEAR:
            begin
                ctl.do_clear = accept;
            end
            mpq_pkg::CMD_PEEK:
            begin
                ctl.status_code = mpq_pkg::ST_DONE;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        priority if (accept)
        begin
            state_next = S_HOLD;
        end
        else if (state_reg == S_HOLD && !result_stall)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/mpq_datapath.sv
// Datapath: row of sorted cells, entry counter and result register.
module mpq_datapath #(
    parameter  int CAPACITY = mpq_pkg::DEFAULT_CAPACITY,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mpq_pkg::ctl_t                ctl,
    output mpq_pkg::dp_stat_t            stat,
    input  logic [mpq_pkg::KEY_W-1:0]    item_key,
    input  logic [mpq_pkg::HANDLE_W-1:0] item_handle,
    output logic                         top_valid,
    output logic [mpq_pkg::KEY_W-1:0]    top_key,
    output logic [mpq_pkg::HANDLE_W-1:0] top_handle,
    output logic [CNT_W-1:0]             entry_count,
    output logic                         queue_empty,
    output logic [mpq_pkg::STATUS_W-1:0] status
);

    logic [mpq_pkg::KEY_W-1:0]    cell_key_reg    [CAPACITY];
    logic [mpq_pkg::KEY_W-1:0]    cell_key_next   [CAPACITY];
    logic [mpq_pkg::HANDLE_W-1:0] cell_handle_reg [CAPACITY];
    logic [mpq_pkg::HANDLE_W-1:0] cell_handle_next[CAPACITY];
    logic [CAPACITY-1:0]          gt;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    logic                         top_valid_reg;
    logic [mpq_pkg::KEY_W-1:0]    top_key_reg;
    logic [mpq_pkg::HANDLE_W-1:0] top_handle_reg;
    logic [CNT_W-1:0]             entry_count_reg;
    logic                         queue_empty_reg;
    logic [mpq_pkg::STATUS_W-1:0] status_reg;

    assign stat.full  = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty = (count_reg == '0);

    // One cell per position; cells at or past the count hold stale words
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        // This cell holds a live key that must move up for the new key
        assign gt[i] = (CNT_W'(i) < count_reg) && (cell_key_reg[i] > item_key);

        always_comb
        begin
            cell_key_next[i]    = cell_key_reg[i];
            cell_handle_next[i] = cell_handle_reg[i];
            if (ctl.do_push)
            begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                begin
                    cell_key_next[i]    = cell_key_reg[(i > 0) ? i - 1 : 0];
                    cell_handle_next[i] = cell_handle_reg[(i > 0) ? i - 1 : 0];
                end
                else if (gt[i] || CNT_W'(i) == count_reg)
                begin
                    cell_key_next[i]    = item_key;
                    cell_handle_next[i] = item_handle;
                end
            end
            else if (ctl.do_pop && i < CAPACITY - 1)
            begin
                cell_key_next[i]    = cell_key_reg[(i < CAPACITY - 1) ? i + 1 : i];
                cell_handle_next[i] = cell_handle_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end

        always_ff @(posedge clk)
        begin
            cell_key_reg[i]    <= cell_key_next[i];
            cell_handle_reg[i] <= cell_handle_next[i];
        end
    end

    // Entry count
    always_comb
    begin
        count_next = count_reg;
        priority if (ctl.do_clear)
        begin
            count_next = '0;
        end
        else if (ctl.do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result word, built from the state after the command
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            top_valid_reg   <= (count_next != '0);
            top_key_reg     <= (count_next != '0) ? cell_key_next[0] : '0;
            top_handle_reg  <= (count_next != '0) ? cell_handle_next[0] : '0;
            entry_count_reg <= count_next;
            queue_empty_reg <= (count_next == '0);
            status_reg      <= ctl.status_code;
        end
    end

    assign top_valid   = top_valid_reg;
    assign top_key     = top_key_reg;
    assign top_handle  = top_handle_reg;
    assign entry_count = entry_count_reg;
    assign queue_empty = queue_empty_reg;
    assign status      = status_reg;

endmodule

>>> hdl/min_priority_queue_top.sv
// Min priority queue: one command word in, one result word out.
//
// Input channel (item_valid / item_stall): cmd, item_key, item_handle.
//   cmd push inserts (key, handle) after every entry with an equal or smaller
//   key, pop removes the smallest entry, clear empties the queue, peek only
//   reports. Output channel (result_valid / result_stall): one word per input
//   word, describing the queue after the command: top_valid, top_key,
//   top_handle (both 0 when empty), entry_count, queue_empty, status
//   (done, push refused when full, pop refused when empty).
// Latency: the result word is valid the cycle after its input word is taken.
// Throughput: one word per cycle while item_stall is low. Each entry sits in
//   its own cell, and each cell compares its key with the incoming key and
//   shifts, so a whole push or pop finishes in the cycle it is accepted.
// Stall: while result_stall holds a waiting word, item_stall is raised and
//   the result word stays put; a word taken in the same cycle frees the
//   register, so a new input word can be accepted then.
// Reset: rst_n clears the entry count and the handshake state; cell contents
//   are not cleared and are never shown before they are written.
module min_priority_queue_top #(
    parameter  int CAPACITY = mpq_pkg::DEFAULT_CAPACITY,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [mpq_pkg::CMD_W-1:0]    cmd,
    input  logic [mpq_pkg::KEY_W-1:0]    item_key,
    input  logic [mpq_pkg::HANDLE_W-1:0] item_handle,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         top_valid,
    output logic [mpq_pkg::KEY_W-1:0]    top_key,
    output logic [mpq_pkg::HANDLE_W-1:0] top_handle,
    output logic [CNT_W-1:0]             entry_count,
    output logic                         queue_empty,
    output logic [mpq_pkg::STATUS_W-1:0] status
);

    mpq_pkg::ctl_t     ctl;
    mpq_pkg::dp_stat_t stat;

    mpq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .ctl          (ctl)
    );

    mpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .item_key    (item_key),
        .item_handle (item_handle),
        .top_valid   (top_valid),
        .top_key     (top_key),
        .top_handle  (top_handle),
        .entry_count (entry_count),
        .queue_empty (queue_empty),
        .status      (status)
    );

endmodule

>>> hdl/mpq_checker.sv
// Port-level checker for the min priority queue, bound to the top level.
`include "min_priority_queue_top_assert.svh"

module mpq_checker #(
    parameter  int CAPACITY = mpq_pkg::DEFAULT_CAPACITY,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_stall,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic                         top_valid,
    input logic [mpq_pkg::KEY_W-1:0]    top_key,
    input logic [mpq_pkg::HANDLE_W-1:0] top_handle,
    input logic [CNT_W-1:0]             entry_count,
    input logic                         queue_empty
);

    // A stalled result word holds
    `MPQ_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(top_key) && $stable(entry_count), "stalled result word changed")

    // No new word while a waiting result is stalled
    `MPQ_ASSERT_NOW(a_no_overrun, result_valid && result_stall, item_stall, "input taken over a stalled result")

    // Empty flag agrees with the top flag and the count
    `MPQ_ASSERT_NOW(a_empty_flag, result_valid, (queue_empty != top_valid) && (queue_empty == (entry_count == '0)), "empty flag inconsistent")

    // Empty queue shows a zero top
    `MPQ_ASSERT_NOW(a_empty_zero, result_valid && !top_valid, (top_key == '0) && (top_handle == '0), "empty queue shows nonzero top")

    // Count never exceeds capacity
    `MPQ_ASSERT_NOW(a_count_max, result_valid, entry_count <= CNT_W'(CAPACITY), "entry count above capacity")

endmodule

bind min_priority_queue_top mpq_checker #(
    .CAPACITY (CAPACITY)
) u_mpq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .top_valid    (top_valid),
    .top_key      (top_key),
    .top_handle   (top_handle),
    .entry_count  (entry_count),
    .queue_empty  (queue_empty)
);

>>> dv/min_priority_queue_checker.sv
// Queue-behavior predictor and result checker for the min priority queue.
`timescale 1ns / 100ps

module min_priority_queue_checker #(
    parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_stall,
    input  logic [mpq_pkg::CMD_W-1:0]    cmd,
    input  logic [mpq_pkg::KEY_W-1:0]    item_key,
    input  logic [mpq_pkg::HANDLE_W-1:0] item_handle,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  logic                         top_valid,
    input  logic [mpq_pkg::KEY_W-1:0]    top_key,
    input  logic [mpq_pkg::HANDLE_W-1:0] top_handle,
    input  logic [CNT_W-1:0]             entry_count,
    input  logic                         queue_empty,
    input  logic [mpq_pkg::STATUS_W-1:0] status,
    output int                           mismatch_count,
    output int                           reports_due
);

    // What the queue should report after one word
    typedef struct {
        logic                         top_valid;
        logic [mpq_pkg::KEY_W-1:0]    top_key;
        logic [mpq_pkg::HANDLE_W-1:0] top_handle;
        logic [CNT_W-1:0]             entry_count;
        logic                         queue_empty;
        logic [mpq_pkg::STATUS_W-1:0] status;
    } queue_report_t;

    // Shadow copy of the queue, smallest key at slot 0
    logic [mpq_pkg::KEY_W-1:0]    shadow_keys[CAPACITY];
    logic [mpq_pkg::HANDLE_W-1:0] shadow_handles[CAPACITY];
    int                           shadow_count;

    queue_report_t       report_q[$];
    queue_report_t       oldest;

    // Apply one command to the shadow queue and return the report it yields
    function automatic queue_report_t apply_command(
        input logic [mpq_pkg::CMD_W-1:0]    c,
        input logic [mpq_pkg::KEY_W-1:0]    k,
        input logic [mpq_pkg::HANDLE_W-1:0] h
    );
        queue_report_t                rpt;
        int                           slot;
        logic [mpq_pkg::STATUS_W-1:0] st;
        st = mpq_pkg::ST_DONE;
        case (c)
            mpq_pkg::CMD_PUSH:
            begin
                if (shadow_count >= CAPACITY)
                    st = mpq_pkg::ST_FULL;
                else
                begin
                    // new entry goes behind every equal or smaller key
                    slot = shadow_count;
                    while (slot > 0 && shadow_keys[slot-1] > k)
                    begin
                        shadow_keys[slot]    = shadow_keys[slot-1];
                        shadow_handles[slot] = shadow_handles[slot-1];
                        slot--;
                    end
                    shadow_keys[slot]    = k;
                    shadow_handles[slot] = h;
                    shadow_count++;
                end
            end
            mpq_pkg::CMD_POP:
            begin
                if (shadow_count == 0)
                    st = mpq_pkg::ST_EMPTY;
                else
                begin
                    for (int i = 1; i < shadow_count; i++)
                    begin
                        shadow_keys[i-1]    = shadow_keys[i];
                        shadow_handles[i-1] = shadow_handles[i];
                    end
                    shadow_count--;
                end
            end
            mpq_pkg::CMD_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        rpt.top_valid   = (shadow_count != 0);
        rpt.top_key     = rpt.top_valid ? shadow_keys[0] : '0;
        rpt.top_handle  = rpt.top_valid ? shadow_handles[0] : '0;
        rpt.entry_count = shadow_count[CNT_W-1:0];
        rpt.queue_empty = !rpt.top_valid;
        rpt.status      = st;
        return rpt;
    endfunction

    // Compare taken result words first, then predict for the taken input word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count   = 0;
            report_q.delete();
            mismatch_count = 0;
            reports_due    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (report_q.size() == 0)
                begin
                    $error("result word with no expected report waiting");
                    mismatch_count++;
                end
                else
                begin
                    oldest = report_q.pop_front();
                    if (top_valid !== oldest.top_valid)
                    begin
                        $error("top_valid: expected %0d, actual %0d",
                               oldest.top_valid, top_valid);
                        mismatch_count++;
                    end
                    if (top_key !== oldest.top_key)
                    begin
                        $error("top_key: expected %h, actual %h", oldest.top_key, top_key);
                        mismatch_count++;
                    end
                    if (top_handle !== oldest.top_handle)
                    begin
                        $error("top_handle: expected %h, actual %h",
                               oldest.top_handle, top_handle);
                        mismatch_count++;
                    end
                    if (entry_count !== oldest.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               oldest.entry_count, entry_count);
                        mismatch_count++;
                    end
                    if (queue_empty !== oldest.queue_empty)
                    begin
                        $error("queue_empty: expected %0d, actual %0d",
                               oldest.queue_empty, queue_empty);
                        mismatch_count++;
                    end
                    if (status !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, status);
                        mismatch_count++;
                    end
                end
            end
            if (item_valid && !item_stall)
                report_q.push_back(apply_command(cmd, item_key, item_handle));
            reports_due = report_q.size();
        end
    end

endmodule

>>> dv/min_priority_queue_top_tb.sv
// Stimulus, clocking and verdict for the min priority queue testbench.
`timescale 1ns / 100ps

module min_priority_queue_top_tb;

    localparam int CAPACITY = mpq_pkg::DEFAULT_CAPACITY;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         item_valid   = 1'b0;
    logic                         item_stall;
    logic [mpq_pkg::CMD_W-1:0]    cmd          = mpq_pkg::CMD_PEEK;
    logic [mpq_pkg::KEY_W-1:0]    item_key     = '0;
    logic [mpq_pkg::HANDLE_W-1:0] item_handle  = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic                         top_valid;
    logic [mpq_pkg::KEY_W-1:0]    top_key;
    logic [mpq_pkg::HANDLE_W-1:0] top_handle;
    logic [CNT_W-1:0]             entry_count;
    logic                         queue_empty;
    logic [mpq_pkg::STATUS_W-1:0] status;

    int                  mismatch_count;
    int                  reports_due;
    int                  words_sent   = 0;
    int                  send_idle_pct = 0;
    int                  stall_pct    = 0;

    min_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .cmd(cmd),
        .item_key(item_key),
        .item_handle(item_handle),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .top_valid(top_valid),
        .top_key(top_key),
        .top_handle(top_handle),
        .entry_count(entry_count),
        .queue_empty(queue_empty),
        .status(status)
    );

    min_priority_queue_checker #(
        .CAPACITY(CAPACITY),
        .CNT_W(CNT_W)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .cmd(cmd),
        .item_key(item_key),
        .item_handle(item_handle),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .top_valid(top_valid),
        .top_key(top_key),
        .top_handle(top_handle),
        .entry_count(entry_count),
        .queue_empty(queue_empty),
        .status(status),
        .mismatch_count(mismatch_count),
        .reports_due(reports_due)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
        result_stall <= ($urandom_range(99, 0) < stall_pct);

    // Hard stop if the run hangs
    initial
    begin
        #2000000;
        $display("min_priority_queue_top regression: fail");
        $finish;
    end

    // Offer one word after random idle cycles, return once it is taken
    task automatic send_word(
        input logic [mpq_pkg::CMD_W-1:0]    c,
        input logic [mpq_pkg::KEY_W-1:0]    k,
        input logic [mpq_pkg::HANDLE_W-1:0] h
    );
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        cmd         <= c;
        item_key    <= k;
        item_handle <= h;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Hold the sender until every report has come back
    task automatic drain_reports();
        item_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
    endtask

    // Keys: many small ones for ties, some extremes, the rest full range
    function automatic logic [mpq_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99, 0);
        if (r < 40)
            return $urandom_range(15, 0);
        else if (r < 50)
            return $urandom_range(1, 0) ? '1 : '0;
        return $urandom;
    endfunction

    // Push-leaning mix so the queue fills and drains over time
    function automatic logic [mpq_pkg::CMD_W-1:0] pick_mixed_cmd();
        int r;
        r = $urandom_range(99, 0);
        if (r < 45)
            return mpq_pkg::CMD_PUSH;
        else if (r < 80)
            return mpq_pkg::CMD_POP;
        else if (r < 95)
            return mpq_pkg::CMD_PEEK;
        return mpq_pkg::CMD_CLEAR;
    endfunction

    // Random segments: mixed traffic, fill-past-full, drain-past-empty, noise
    task automatic run_phase(input int words, input int idle_pct, input int stl_pct);
        int                        target;
        int                        seg;
        int                        len;
        logic [mpq_pkg::CMD_W-1:0] c;
        send_idle_pct = idle_pct;
        stall_pct     = stl_pct;
        target        = words_sent + words;
        while (words_sent < target)
        begin
            seg = $urandom_range(99, 0);
            len = (seg >= 55 && seg < 85) ? $urandom_range(CAPACITY + 6, CAPACITY + 2)
                                          : $urandom_range(60, 10);
            for (int i = 0; i < len; i++)
            begin
                if (seg < 55)
                    c = pick_mixed_cmd();
                else if (seg < 70)
                    c = mpq_pkg::CMD_PUSH;
                else if (seg < 85)
                    c = mpq_pkg::CMD_POP;
                else
                    c = mpq_pkg::CMD_W'($urandom_range(3, 0));
                send_word(c, pick_key(), mpq_pkg::HANDLE_W'($urandom_range(65535, 0)));
            end
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-queue cases, key extremes, equal-key order, clear
        send_word(mpq_pkg::CMD_PEEK,  '0,   '0);
        send_word(mpq_pkg::CMD_POP,   '0,   '0);
        send_word(mpq_pkg::CMD_CLEAR, '0,   '0);
        send_word(mpq_pkg::CMD_PUSH,  '1,   '1);
        send_word(mpq_pkg::CMD_PUSH,  '0,   '0);
        send_word(mpq_pkg::CMD_PEEK,  '1,   '1);
        send_word(mpq_pkg::CMD_PUSH,  32'd5, 16'h0001);
        send_word(mpq_pkg::CMD_PUSH,  32'd5, 16'h0002);
        send_word(mpq_pkg::CMD_PUSH,  32'd5, 16'h0003);
        send_word(mpq_pkg::CMD_PUSH,  '1,   16'h1234);
        repeat (6)
            send_word(mpq_pkg::CMD_POP, '0, '0);
        send_word(mpq_pkg::CMD_POP,   '0,   '0);
        send_word(mpq_pkg::CMD_PUSH,  32'd7, 16'hAAAA);
        send_word(mpq_pkg::CMD_PUSH,  32'd3, 16'h5555);
        send_word(mpq_pkg::CMD_CLEAR, '1,   '1);
        send_word(mpq_pkg::CMD_PEEK,  '0,   '0);
        drain_reports();

        // random phases, with full drains between some of them
        run_phase(380, 0, 0);
        drain_reports();
        run_phase(380, 52, 0);
        run_phase(380, 0, 52);
        drain_reports();
        run_phase(385, 16, 16);

        drain_reports();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("min_priority_queue_top regression: pass");
        else
            $display("min_priority_queue_top regression: fail");
        $finish;
    end

endmodule
